// File: design/l2_l4_header_parser_defines.svh
// Assertion macros for the L2-L4 header parser.
// Used by the top level; expects clk and arst_n in scope.
`ifndef L2_L4_HEADER_PARSER_DEFINES_SVH
`define L2_L4_HEADER_PARSER_DEFINES_SVH

// checked only out of reset
`define L2L4_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define L2L4_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/l2l4_pkg.sv
// Types and constants of the L2-L4 header parser.
// No dependencies; imported by every module of the block.
package l2l4_pkg;

	typedef enum logic [2:0] {
		LAYER_UNPARSED = 3'd0,
		LAYER_ETH      = 3'd1,
		LAYER_VLAN     = 3'd2,
		LAYER_IPV4     = 3'd3,
		LAYER_TCP      = 3'd4,
		LAYER_UDP      = 3'd5,
		LAYER_PAYLOAD  = 3'd6
	} layer_t;

	localparam logic [7:0]  START_RAW_IPV4 = 8'h45;
	localparam logic [7:0]  START_UNPARSED = 8'h60;
	localparam logic [15:0] TYPE_VLAN      = 16'h8100;
	localparam logic [15:0] TYPE_IPV4      = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	localparam logic [4:0] ETH_TYPE_HI_IDX  = 5'd12;
	localparam logic [4:0] ETH_LAST_IDX     = 5'd13;
	localparam logic [4:0] VLAN_TYPE_HI_IDX = 5'd2;
	localparam logic [4:0] VLAN_LAST_IDX    = 5'd3;
	localparam logic [4:0] IPV4_PROTO_IDX   = 5'd9;
	localparam logic [4:0] IPV4_LAST_IDX    = 5'd19;
	localparam logic [4:0] TCP_LAST_IDX     = 5'd19;
	localparam logic [4:0] UDP_LAST_IDX     = 5'd7;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	typedef struct packed {
		logic eth;
		logic vlan;
		logic ipv4;
		logic tcp;
		logic udp;
	} hdr_flags_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} in_word_t;

	typedef struct packed {
		layer_t     layer;
		logic [4:0] byte_in_layer;
		logic       end_of_packet;
		hdr_flags_t flags;
		logic [15:0] pkt_len;
	} tag_t;

endpackage

// File: design/l2l4_in_stage.sv
// Input register of the L2-L4 header parser.
// Depends on l2l4_pkg.
module l2l4_in_stage
	import l2l4_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  in_word_t in_word,
	output logic     in_ready,
	output logic     out_valid,
	output in_word_t out_word,
	input  logic     out_ready
);

	logic     valid_s1;
	in_word_t word_s1;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_word  = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

endmodule

// File: design/l2l4_tagger.sv
// Per-packet parse state and byte tagging logic.
// Depends on l2l4_pkg; state moves on each advanced word.
module l2l4_tagger
	import l2l4_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     advance,
	input  in_word_t word,
	output tag_t     tag
);

	logic [15:0] count_q;
	layer_t      layer_q;
	logic [4:0]  idx_q;
	logic [7:0]  type_hi_q;
	hdr_flags_t  flags_q;

	logic [15:0] count_d;
	layer_t      layer_d;
	logic [4:0]  idx_d;
	logic [7:0]  type_hi_d;
	hdr_flags_t  flags_d;

	layer_t      cur;
	logic [4:0]  idx;
	hdr_flags_t  flags;
	logic [15:0] count_inc;
	logic [15:0] type_word;

	always_comb begin
		cur   = layer_q;
		idx   = idx_q;
		flags = flags_q;
		// first byte decides how the packet starts
		if (count_q == 16'd0) begin
			idx = 5'd0;
			if (word.data == START_RAW_IPV4) begin
				cur        = LAYER_IPV4;
				flags.ipv4 = 1'b1;
			end else if (word.data == START_UNPARSED) begin
				cur = LAYER_UNPARSED;
			end else begin
				cur       = LAYER_ETH;
				flags.eth = 1'b1;
			end
		end

		type_word = {type_hi_q, word.data};
		type_hi_d = type_hi_q;
		layer_d   = cur;
		idx_d     = idx + 5'd1;
		flags_d   = flags;

		case (cur)
			LAYER_ETH: begin
				if (idx == ETH_TYPE_HI_IDX) begin
					type_hi_d = word.data;
				end
				if (idx >= ETH_LAST_IDX) begin
					idx_d = 5'd0;
					if (type_word == TYPE_VLAN) begin
						flags_d.vlan = 1'b1;
						layer_d      = LAYER_VLAN;
					end else if (type_word == TYPE_IPV4) begin
						flags_d.ipv4 = 1'b1;
						layer_d      = LAYER_IPV4;
					end else begin
						layer_d = LAYER_PAYLOAD;
					end
				end
			end
			LAYER_VLAN: begin
				if (idx == VLAN_TYPE_HI_IDX) begin
					type_hi_d = word.data;
				end
				if (idx >= VLAN_LAST_IDX) begin
					idx_d = 5'd0;
					// a stacked tag is not followed further
					if (type_word == TYPE_IPV4) begin
						flags_d.ipv4 = 1'b1;
						layer_d      = LAYER_IPV4;
					end else begin
						layer_d = LAYER_PAYLOAD;
					end
				end
			end
			LAYER_IPV4: begin
				if (idx == IPV4_PROTO_IDX) begin
					if (word.data == PROTO_TCP) begin
						flags_d.tcp = 1'b1;
					end else if (word.data == PROTO_UDP) begin
						flags_d.udp = 1'b1;
					end
				end
				// tcp/udp flags double as the held protocol decision
				if (idx >= IPV4_LAST_IDX) begin
					idx_d = 5'd0;
					if (flags.tcp) begin
						layer_d = LAYER_TCP;
					end else if (flags.udp) begin
						layer_d = LAYER_UDP;
					end else begin
						layer_d = LAYER_PAYLOAD;
					end
				end
			end
			LAYER_TCP: begin
				if (idx >= TCP_LAST_IDX) begin
					idx_d   = 5'd0;
					layer_d = LAYER_PAYLOAD;
				end
			end
			LAYER_UDP: begin
				if (idx >= UDP_LAST_IDX) begin
					idx_d   = 5'd0;
					layer_d = LAYER_PAYLOAD;
				end
			end
			default: begin
				idx_d = 5'd0;
			end
		endcase

		count_inc = (count_q == LEN_MAX) ? count_q : count_q + 16'd1;
		count_d   = count_inc;

		tag.layer         = cur;
		tag.byte_in_layer = (cur == LAYER_UNPARSED || cur == LAYER_PAYLOAD) ? 5'd0 : idx;
		tag.end_of_packet = word.last;
		// on the last byte, flags as they stand after it, before the end-of-packet clear; else zero
		tag.flags         = word.last ? flags_d : '0;
		tag.pkt_len       = word.last ? count_inc : 16'd0;

		if (word.last) begin
			count_d   = 16'd0;
			layer_d   = LAYER_ETH;
			idx_d     = 5'd0;
			type_hi_d = 8'd0;
			flags_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= 16'd0;
			layer_q   <= LAYER_ETH;
			idx_q     <= 5'd0;
			type_hi_q <= 8'd0;
			flags_q   <= '0;
		end else if (advance) begin
			count_q   <= count_d;
			layer_q   <= layer_d;
			idx_q     <= idx_d;
			type_hi_q <= type_hi_d;
			flags_q   <= flags_d;
		end
	end

endmodule

// File: design/l2_l4_header_parser.sv
// Pipeline: a byte passes the input register (word_s1), then the result register (tag_s2), before it leaves.
// Throughput: one byte per cycle while m_tready is high; a low m_tready backs up through
// the result and input registers, and s_tready drops once both hold a word.
// Reset: arst_n clears both valid bits and the per-packet state; the next byte starts a packet.
// Depends on l2l4_pkg, l2l4_in_stage, l2l4_tagger and the defines header.
`include "l2_l4_header_parser_defines.svh"

module l2_l4_header_parser
	import l2l4_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [2:0] layer, [7:3] byte_in_layer, [8] eth_seen,
	                               // [9] vlan_seen, [10] ipv4_seen, [11] tcp_seen,
	                               // [12] udp_seen, [28:13] pkt_len, [31:29] zero
	output logic        m_tlast    // end_of_packet
);

	in_word_t in_word;
	in_word_t word_s1;
	logic     valid_s1;
	logic     ready_s2;
	logic     advance;
	tag_t     tag;

	logic     valid_s2;
	tag_t     tag_s2;

	assign in_word.data = s_tdata;
	assign in_word.last = s_tlast;

	assign ready_s2 = !valid_s2 || m_tready;
	assign advance  = valid_s1 && ready_s2;

	l2l4_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_word   (in_word),
		.in_ready  (s_tready),
		.out_valid (valid_s1),
		.out_word  (word_s1),
		.out_ready (ready_s2)
	);

	l2l4_tagger u_tagger (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.word    (word_s1),
		.tag     (tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tag_s2 <= tag;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = tag_s2.end_of_packet;
	assign m_tdata  = {3'b000, tag_s2.pkt_len,
		tag_s2.flags.udp, tag_s2.flags.tcp, tag_s2.flags.ipv4,
		tag_s2.flags.vlan, tag_s2.flags.eth,
		tag_s2.byte_in_layer, tag_s2.layer};

	`L2L4_ASSERT(a_no_flags_mid_packet,
		valid_s2 && !tag_s2.end_of_packet |-> tag_s2.flags == '0 && tag_s2.pkt_len == 16'd0,
		"flags or length on a word that is not the end of packet")
	`L2L4_ASSERT(a_tcp_udp_exclusive,
		valid_s2 |-> !(tag_s2.flags.tcp && tag_s2.flags.udp),
		"tcp and udp both marked valid")
	`L2L4_ASSERT(a_vlan_needs_eth,
		valid_s2 && tag_s2.flags.vlan |-> tag_s2.flags.eth,
		"vlan marked valid without ethernet")
	`L2L4_ASSERT_ALWAYS(a_index_zero_outside_headers,
		valid_s2 && (tag_s2.layer == LAYER_PAYLOAD || tag_s2.layer == LAYER_UNPARSED)
			|-> tag_s2.byte_in_layer == 5'd0,
		"nonzero index on payload or unparsed word")

endmodule

// File: tb/l2_l4_header_parser_checker.sv
// Scoreboard for the L2-L4 header parser. It tags every byte word taken on
// the slave side and compares the tag with the next word on the master side.
// Depends on l2l4_pkg.
module l2_l4_header_parser_checker
	import l2l4_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [2:0] layer, [7:3] byte_in_layer, [12:8] flags,
	                               // [28:13] pkt_len, [31:29] zero
	input  logic        m_tlast,   // end_of_packet
	output int          errors,
	output int          open_tags
);
	timeunit 1ns;
	timeprecision 1ps;

	// parser state as seen by the scoreboard
	logic [15:0] seen_bytes;
	layer_t      cur_layer;
	logic [4:0]  hdr_index;
	logic [15:0] ether_type;
	logic [7:0]  ip_proto;
	hdr_flags_t  found;

	tag_t tags_due[$];

	function void clear_packet_state();
		seen_bytes = '0;
		cur_layer  = LAYER_ETH;
		hdr_index  = '0;
		ether_type = '0;
		ip_proto   = '0;
		found      = '0;
	endfunction

	function void enter(input layer_t next);
		cur_layer = next;
		hdr_index = '0;
	endfunction

	// an Ethernet or VLAN type picks IPv4 or plain payload
	function void after_ether_type();
		if (ether_type == TYPE_IPV4) begin
			found.ipv4 = 1'b1;
			enter(LAYER_IPV4);
		end else begin
			enter(LAYER_PAYLOAD);
		end
	endfunction

	function tag_t tag_byte(input logic [7:0] b, input logic fin);
		tag_t t;
		t = '0;
		// first byte picks raw IPv4, unparsed or Ethernet
		if (seen_bytes == 16'd0) begin
			hdr_index = '0;
			if (b == START_RAW_IPV4) begin
				cur_layer  = LAYER_IPV4;
				found.ipv4 = 1'b1;
			end else if (b == START_UNPARSED) begin
				cur_layer = LAYER_UNPARSED;
			end else begin
				cur_layer = LAYER_ETH;
				found.eth = 1'b1;
			end
		end
		t.layer = cur_layer;
		if (cur_layer != LAYER_UNPARSED && cur_layer != LAYER_PAYLOAD)
			t.byte_in_layer = hdr_index;
		case (cur_layer)
			LAYER_ETH: begin
				if (hdr_index == ETH_TYPE_HI_IDX)
					ether_type = {b, 8'h00};
				else if (hdr_index == ETH_LAST_IDX)
					ether_type[7:0] = b;
				if (hdr_index >= ETH_LAST_IDX) begin
					if (ether_type == TYPE_VLAN) begin
						found.vlan = 1'b1;
						enter(LAYER_VLAN);
					end else begin
						after_ether_type();
					end
				end else begin
					hdr_index++;
				end
			end
			LAYER_VLAN: begin
				if (hdr_index == VLAN_TYPE_HI_IDX)
					ether_type = {b, 8'h00};
				else if (hdr_index == VLAN_LAST_IDX)
					ether_type[7:0] = b;
				if (hdr_index >= VLAN_LAST_IDX)
					after_ether_type();
				else
					hdr_index++;
			end
			LAYER_IPV4: begin
				if (hdr_index == IPV4_PROTO_IDX) begin
					ip_proto = b;
					if (b == PROTO_TCP)
						found.tcp = 1'b1;
					else if (b == PROTO_UDP)
						found.udp = 1'b1;
				end
				if (hdr_index >= IPV4_LAST_IDX) begin
					if (ip_proto == PROTO_TCP)
						enter(LAYER_TCP);
					else if (ip_proto == PROTO_UDP)
						enter(LAYER_UDP);
					else
						enter(LAYER_PAYLOAD);
				end else begin
					hdr_index++;
				end
			end
			LAYER_TCP: begin
				if (hdr_index >= TCP_LAST_IDX)
					enter(LAYER_PAYLOAD);
				else
					hdr_index++;
			end
			LAYER_UDP: begin
				if (hdr_index >= UDP_LAST_IDX)
					enter(LAYER_PAYLOAD);
				else
					hdr_index++;
			end
			default: begin
				hdr_index = '0;
			end
		endcase
		if (seen_bytes != LEN_MAX)
			seen_bytes++;
		if (fin) begin
			t.end_of_packet = 1'b1;
			t.flags         = found;
			t.pkt_len       = seen_bytes;
			clear_packet_state();
		end
		return t;
	endfunction

	// flags print as eth,vlan,ipv4,tcp,udp
	function void report(input string what, input tag_t want, input tag_t got,
		input logic [2:0] pad);
		errors++;
		if (errors <= 10) begin
			$display("%0t %s: want layer %0d idx %0d eop %0b flags %05b len %0d",
				$realtime, what, want.layer, want.byte_in_layer, want.end_of_packet,
				want.flags, want.pkt_len);
			$display("    got layer %0d idx %0d eop %0b flags %05b len %0d pad %0d",
				got.layer, got.byte_in_layer, got.end_of_packet, got.flags,
				got.pkt_len, pad);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		tag_t want;
		tag_t got;
		if (!arst_n) begin
			clear_packet_state();
			tags_due.delete();
			open_tags <= 0;
		end else begin
			if (s_tvalid && s_tready)
				tags_due.push_back(tag_byte(s_tdata, s_tlast));
			if (m_tvalid && m_tready) begin
				got               = '0;
				got.layer         = layer_t'(m_tdata[2:0]);
				got.byte_in_layer = m_tdata[7:3];
				got.end_of_packet = m_tlast;
				got.flags.eth     = m_tdata[8];
				got.flags.vlan    = m_tdata[9];
				got.flags.ipv4    = m_tdata[10];
				got.flags.tcp     = m_tdata[11];
				got.flags.udp     = m_tdata[12];
				got.pkt_len       = m_tdata[28:13];
				if (tags_due.size() == 0) begin
					report("word with no tag expected", '0, got, m_tdata[31:29]);
				end else begin
					want = tags_due.pop_front();
					if (got.layer !== want.layer || got.byte_in_layer !== want.byte_in_layer
						|| got.end_of_packet !== want.end_of_packet
						|| got.flags !== want.flags
						|| got.pkt_len !== want.pkt_len
						|| m_tdata[31:29] !== 3'b000)
						report("tag mismatch", want, got, m_tdata[31:29]);
				end
			end
			open_tags <= tags_due.size();
		end
	end

endmodule

// File: tb/l2_l4_header_parser_test.sv
// Top of the L2-L4 header parser testbench: clock, reset, packet stimulus and
// random stalls on both sides; the verdict comes from the checker's counts.
// Depends on l2l4_pkg, l2_l4_header_parser and l2_l4_header_parser_checker.
module l2_l4_header_parser_test;
	timeunit 1ns;
	timeprecision 1ps;
	import l2l4_pkg::*;

	localparam int LIMIT        = 2_000_000;
	localparam int RANDOM_BYTES = 160;
	localparam int SETTLE       = 8;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [31:0] m_tdata;
	wire         m_tlast;

	int check_errors;
	int tags_open;
	int cycle_count = 0;
	int frames_sent = 0;
	int bytes_sent  = 0;
	int random_sent = 0;
	bit calm        = 1'b0;

	logic [7:0] frame_bytes[$];

	l2_l4_header_parser dut (.*);

	l2_l4_header_parser_checker scoreboard (
		.*,
		.errors    (check_errors),
		.open_tags (tags_open)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// result side: short stalls between ready stretches of varied length
	initial begin
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			m_tready <= 1'b1;
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(20, 60)) @(posedge clk);
			else
				repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	function void put_bytes(input int n);
		repeat (n) frame_bytes.push_back(8'($urandom));
	endfunction

	function void put_eth(input logic [15:0] etype);
		logic [7:0] first;
		first = 8'($urandom);
		while (first == START_RAW_IPV4 || first == START_UNPARSED)
			first = 8'($urandom);
		frame_bytes.push_back(first);
		put_bytes(11);
		frame_bytes.push_back(etype[15:8]);
		frame_bytes.push_back(etype[7:0]);
	endfunction

	function void put_vlan(input logic [15:0] etype);
		put_bytes(2);
		frame_bytes.push_back(etype[15:8]);
		frame_bytes.push_back(etype[7:0]);
	endfunction

	function void put_ipv4(input logic [7:0] proto);
		frame_bytes.push_back(START_RAW_IPV4);
		put_bytes(8);
		frame_bytes.push_back(proto);
		put_bytes(10);
	endfunction

	function logic [15:0] pick_type();
		case ($urandom_range(0, 5))
			0, 1, 2: return TYPE_IPV4;
			3:       return TYPE_VLAN;
			4:       return {TYPE_IPV4[15:8], 8'($urandom_range(1, 255))};
			default: return 16'($urandom);
		endcase
	endfunction

	function void put_ip_stack();
		logic [7:0] proto;
		case ($urandom_range(0, 4))
			0, 1:    proto = PROTO_TCP;
			2, 3:    proto = PROTO_UDP;
			default: proto = 8'($urandom);
		endcase
		put_ipv4(proto);
		if (proto == PROTO_TCP)
			put_bytes(20);
		else if (proto == PROTO_UDP)
			put_bytes(8);
	endfunction

	function void build_random_frame();
		logic [15:0] etype;
		int kind;
		int cut;
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			if ($urandom_range(0, 3) == 0) begin
				put_ip_stack();
			end else begin
				etype = pick_type();
				put_eth(etype);
				if (etype == TYPE_VLAN) begin
					etype = pick_type();
					put_vlan(etype);
				end
				if (etype == TYPE_IPV4)
					put_ip_stack();
			end
			put_bytes($urandom_range(0, 12));
			// cut short anywhere, or spoil one byte
			if ($urandom_range(0, 2) == 0) begin
				cut = $urandom_range(1, frame_bytes.size());
				while (frame_bytes.size() > cut)
					void'(frame_bytes.pop_back());
			end else if ($urandom_range(0, 4) == 0) begin
				frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom);
			end
		end else if (kind < 8) begin
			put_bytes($urandom_range(1, 24));
			if ($urandom_range(0, 2) == 0)
				frame_bytes[0] = $urandom_range(0, 1) ? START_RAW_IPV4 : START_UNPARSED;
		end else begin
			frame_bytes.push_back(START_UNPARSED);
			put_bytes($urandom_range(0, 16));
		end
	endfunction

	task automatic drive_byte(input logic [7:0] b, input logic fin);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			drive_byte(frame_bytes[i], i == frame_bytes.size() - 1);
		frames_sent++;
		bytes_sent += frame_bytes.size();
		frame_bytes.delete();
	endtask

	// hold the sender until every tag has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (tags_open != 0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte packets: each start kind
		frame_bytes.push_back(START_RAW_IPV4);
		send_frame();
		frame_bytes.push_back(START_UNPARSED);
		send_frame();
		frame_bytes.push_back(8'h00);
		send_frame();
		// Ethernet ends after the type high byte: no VLAN or IPv4 decision
		frame_bytes.push_back(8'hFF);
		put_bytes(11);
		frame_bytes.push_back(TYPE_IPV4[15:8]);
		send_frame();
		put_eth(TYPE_IPV4);
		put_ipv4(PROTO_TCP);
		put_bytes(24);
		send_frame();
		put_eth(TYPE_VLAN);
		put_vlan(TYPE_IPV4);
		put_ipv4(PROTO_UDP);
		put_bytes(11);
		send_frame();
		// stacked tags stop parsing
		put_eth(TYPE_VLAN);
		put_vlan(TYPE_VLAN);
		put_bytes(6);
		send_frame();
		put_eth(16'hFFFF);
		put_bytes(3);
		send_frame();
		put_ipv4(8'd1);
		put_bytes(2);
		send_frame();
		put_ipv4(PROTO_TCP);
		put_bytes(7);
		send_frame();
		// IPv4 cut right at the protocol byte
		put_eth(TYPE_IPV4);
		put_ipv4(PROTO_UDP);
		while (frame_bytes.size() > 24)
			void'(frame_bytes.pop_back());
		send_frame();
		frame_bytes.push_back(START_UNPARSED);
		frame_bytes.push_back(START_RAW_IPV4);
		put_bytes(4);
		send_frame();
		drain();

		while (random_sent < RANDOM_BYTES) begin
			if (random_sent >= RANDOM_BYTES * 3 / 4)
				calm = 1'b1;
			build_random_frame();
			random_sent += frame_bytes.size();
			send_frame();
		end
		drain();
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d packets, %0d bytes: all start kinds, VLAN and stacked VLAN,",
			frames_sent, bytes_sent);
		$display("TCP, UDP, odd types and protocols, and headers cut short anywhere");
		if (check_errors == 0 && tags_open == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/l2l4_pkg.sv
design/l2l4_in_stage.sv
design/l2l4_tagger.sv
design/l2_l4_header_parser.sv
tb/l2_l4_header_parser_checker.sv
tb/l2_l4_header_parser_test.sv
